@@ design/btmx_pkg.sv @@
package btmx_pkg;

  localparam int KeyBits   = 32;
  localparam int NodeCount = 4096;
  localparam int NodeW     = $clog2(NodeCount);
  localparam int FreeW     = NodeW + 1;

  // Highest next-free value that still leaves KeyBits nodes for one insert
  localparam logic [FreeW-1:0] PoolLimit = FreeW'(NodeCount - KeyBits);
  localparam logic [FreeW-1:0] CountMax  = '1;

  localparam logic KindInsert = 1'b0;
  localparam logic KindQuery  = 1'b1;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  typedef logic [NodeW-1:0] node_idx_t;

  // One trie node: two child indices, zero means null
  typedef struct packed {
    node_idx_t c1;
    node_idx_t c0;
  } node_t;

endpackage

@@ design/btmx_node_ram.sv @@
module btmx_node_ram
  import btmx_pkg::*;
(
  input  logic      clk_i,
  input  logic      re_i,
  input  node_idx_t raddr_i,
  output node_t     rdata_o,
  input  logic      we_i,
  input  node_idx_t waddr_i,
  input  node_t     wdata_i
);

  node_t mem [NodeCount];
  node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/binary_trie_max_xor_unit.sv @@
// Maximum-XOR trie unit. Requests carry kind (0 insert, 1 query) and a
// 32-bit key; each request gives exactly one result with best_xor and a
// status (0 ok, 1 insert rejected because fewer than 32 free nodes remain,
// 2 query while no key is stored). Requests are taken one at a time: a
// request that walks the trie issues the root read in the accepting cycle,
// then reads one trie level at a time, at most 32 levels, through the
// single read port of the 4096-node memory, then retires through the done
// state, and a rejected insert or empty query goes straight to done.
// in_stall_o is high while a request is in progress; a finished result
// waits in the output register, and the next request is accepted while
// it waits, in the cycle after the result register loads.
// Only the root node has a valid flag, so no clearing pass follows reset.
module binary_trie_max_xor_unit
  import btmx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [31:0] key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] best_xor_o,
  output logic [1:0]  status_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [FreeW-1:0]  free_q, free_d;      // next node to allocate
  logic [FreeW-1:0]  count_q, count_d;    // accepted inserts, saturating
  logic              root_vld_q, root_vld_d;
  logic              out_valid_q, out_valid_d;
  logic              fresh_q, fresh_d;    // below here every node is new
  logic              first_q, first_d;    // current read is the root

  logic              kind_q, kind_d;
  logic [KeyBits-1:0] key_q, key_d;       // shifted, MSB is current bit
  logic [KeyBits-1:0] mask_q, mask_d;     // one-hot current level
  logic [KeyBits-1:0] acc_q, acc_d;
  node_idx_t         cur_q, cur_d;
  logic [1:0]        st_q, st_d;
  logic [31:0]       best_q, best_d;
  logic [1:0]        ost_q, ost_d;

  logic      re, we;
  node_idx_t raddr, waddr;
  node_t     wdata, rdata, node;
  logic      bit_k, last;
  node_idx_t own_c, opp_c;
  logic      out_free;

  btmx_node_ram u_ram (
    .clk_i   (clk_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  // The root reads as empty until its first write
  assign node  = (first_q && !root_vld_q) ? '0 : rdata;
  assign bit_k = key_q[KeyBits-1];
  assign last  = mask_q[0];
  assign own_c = bit_k ? node.c1 : node.c0;
  assign opp_c = bit_k ? node.c0 : node.c1;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    free_d      = free_q;
    count_d     = count_q;
    root_vld_d  = root_vld_q;
    fresh_d     = fresh_q;
    first_d     = first_q;
    kind_d      = kind_q;
    key_d       = key_q;
    mask_d      = mask_q;
    acc_d       = acc_q;
    cur_d       = cur_q;
    st_d        = st_q;
    best_d      = best_q;
    ost_d       = ost_q;
    out_valid_d = out_valid_q && out_stall_i;
    re          = 1'b0;
    raddr       = '0;
    we          = 1'b0;
    waddr       = cur_q;
    wdata       = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          key_d   = KeyBits'(key_i);
          mask_d  = {1'b1, {(KeyBits-1){1'b0}}};
          acc_d   = '0;
          cur_d   = '0;
          fresh_d = 1'b0;
          first_d = 1'b1;
          st_d    = StOk;
          if (kind_i == KindInsert) begin
            if (free_q > PoolLimit) begin
              st_d    = StFull;
              state_d = S_DONE;
            end else begin
              if (count_q != CountMax) begin
                count_d = count_q + 1'b1;
              end
              re      = 1'b1;
              state_d = S_WALK;
            end
          end else begin
            if (count_q == '0) begin
              st_d    = StEmpty;
              state_d = S_DONE;
            end else begin
              re      = 1'b1;
              state_d = S_WALK;
            end
          end
        end
      end

      S_WALK: begin
        key_d   = key_q << 1;
        mask_d  = mask_q >> 1;
        first_d = 1'b0;
        if (kind_q == KindInsert) begin
          if (fresh_q) begin
            // new node: only the child on the key path is set
            we     = 1'b1;
            wdata  = '0;
            if (bit_k) begin
              wdata.c1 = free_q[NodeW-1:0];
            end else begin
              wdata.c0 = free_q[NodeW-1:0];
            end
            free_d = free_q + 1'b1;
            cur_d  = free_q[NodeW-1:0];
          end else if (own_c != '0) begin
            cur_d = own_c;
            if (!last) begin
              re    = 1'b1;
              raddr = own_c;
            end
          end else begin
            // path ends here: link a new child into the existing node
            we    = 1'b1;
            wdata = node;
            if (bit_k) begin
              wdata.c1 = free_q[NodeW-1:0];
            end else begin
              wdata.c0 = free_q[NodeW-1:0];
            end
            if (cur_q == '0) begin
              root_vld_d = 1'b1;
            end
            free_d  = free_q + 1'b1;
            cur_d   = free_q[NodeW-1:0];
            fresh_d = 1'b1;
          end
          if (last) begin
            state_d = S_DONE;
          end
        end else begin
          if (opp_c != '0) begin
            cur_d = opp_c;
            acc_d = acc_q | mask_q;
            if (!last) begin
              re    = 1'b1;
              raddr = opp_c;
            end
            if (last) begin
              state_d = S_DONE;
            end
          end else if (own_c != '0) begin
            cur_d = own_c;
            if (!last) begin
              re    = 1'b1;
              raddr = own_c;
            end
            if (last) begin
              state_d = S_DONE;
            end
          end else begin
            // dead end: keep bits found so far
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        // leaf of a fresh path gets null children
        if ((kind_q == KindInsert) && fresh_q) begin
          we    = 1'b1;
          waddr = cur_q;
          wdata = '0;
        end
        if (out_free) begin
          best_d      = 32'(acc_q);
          ost_d       = st_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= FreeW'(1);
      count_q     <= '0;
      root_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fresh_q     <= 1'b0;
      first_q     <= 1'b0;
      kind_q      <= KindInsert;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      count_q     <= count_d;
      root_vld_q  <= root_vld_d;
      out_valid_q <= out_valid_d;
      fresh_q     <= fresh_d;
      first_q     <= first_d;
      kind_q      <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    mask_q <= mask_d;
    acc_q  <= acc_d;
    cur_q  <= cur_d;
    st_q   <= st_d;
    best_q <= best_d;
    ost_q  <= ost_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign best_xor_o  = best_q;
  assign status_o    = ost_q;

endmodule

@@ sim/binary_trie_max_xor_unit_test.sv @@
`timescale 1ns / 100ps

// Checks the max-XOR trie unit against a trie predictor that the testbench
// keeps itself. A driver feeds requests from a queue; a monitor compares
// each result with the oldest expected result.
module binary_trie_max_xor_unit_test
  import btmx_pkg::*;
();

  localparam int CycleLimit  = 500_000;
  localparam int PrefixCount = 16;
  localparam int DrainCycles = 40;   // margin for the last walk to retire
  localparam int MaxReported = 100;  // keep the log short on a broken build

  typedef struct packed {
    logic        kind;
    logic [31:0] key;
  } request_t;

  typedef struct packed {
    logic [31:0] best;
    logic [1:0]  status;
    logic        kind;
    logic [31:0] key;
  } xor_result_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        kind_i      = KindInsert;
  logic [31:0] key_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] best_xor_o;
  logic [1:0]  status_o;

  request_t    request_q[$];     // requests not yet presented
  xor_result_t xor_result_q[$];  // results owed by the unit, oldest first
  logic [31:0] sent_keys[$];     // keys offered for insert, for query picks
  logic [21:0] prefixes[PrefixCount];

  // Predictor state: mirror of the node memory and its counters
  node_t       trie_mem[NodeCount];
  int          next_free;
  int          key_total;
  int          full_rejects;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int          mismatches     = 0;
  int          cycle_count    = 0;

  binary_trie_max_xor_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .best_xor_o  (best_xor_o),
    .status_o    (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MaxReported) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
    mismatches++;
  endtask

  // Works out the result of one accepted request and updates the trie mirror.
  // Inserts walk from the top key bit down, allocating missing children;
  // queries prefer the opposite child at each level.
  function automatic xor_result_t trie_predict(input request_t req);
    xor_result_t res;
    int          cur;
    int          nxt;
    int          lvl;
    res.best   = '0;
    res.status = StOk;
    res.kind   = req.kind;
    res.key    = req.key;
    cur        = 0;
    if (req.kind == KindInsert) begin
      // reject outright when one full-length path might not fit
      if (NodeCount - next_free < KeyBits) begin
        res.status = StFull;
        full_rejects++;
      end else begin
        for (lvl = KeyBits - 1; lvl >= 0; lvl--) begin
          nxt = req.key[lvl] ? trie_mem[cur].c1 : trie_mem[cur].c0;
          if (nxt == 0) begin
            nxt = next_free;
            next_free++;
            trie_mem[nxt] = '0;
            if (req.key[lvl]) begin
              trie_mem[cur].c1 = node_idx_t'(nxt);
            end else begin
              trie_mem[cur].c0 = node_idx_t'(nxt);
            end
          end
          cur = nxt;
        end
        // duplicates count too; saturate at the counter's top
        if (key_total < int'(CountMax)) begin
          key_total++;
        end
      end
    end else if (key_total == 0) begin
      res.status = StEmpty;
    end else begin
      for (lvl = KeyBits - 1; lvl >= 0; lvl--) begin
        nxt = req.key[lvl] ? trie_mem[cur].c0 : trie_mem[cur].c1;
        if (nxt != 0) begin
          res.best[lvl] = 1'b1;
          cur = nxt;
        end else begin
          nxt = req.key[lvl] ? trie_mem[cur].c1 : trie_mem[cur].c0;
          if (nxt == 0) begin
            break;  // dead end: keep the bits found so far
          end
          cur = nxt;
        end
      end
    end
    return res;
  endfunction

  // Driver: holds a request until it is taken, then may present the next one
  // in the same cycle or idle for a while.
  always @(posedge clk_i) begin : drive
    request_t req;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        req.kind = kind_i;
        req.key  = key_i;
        xor_result_q.push_back(trie_predict(req));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          req = request_q.pop_front();
          in_valid_i <= 1'b1;
          kind_i     <= req.kind;
          key_i      <= req.key;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result, stalls the output at random
  always @(posedge clk_i) begin : watch
    xor_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (xor_result_q.size() == 0) begin
          report_mismatch($sformatf("result best_xor %h status %0d with none pending",
                                    best_xor_o, status_o));
        end else begin
          exp_r = xor_result_q.pop_front();
          if (best_xor_o !== exp_r.best) begin
            report_mismatch($sformatf("best_xor %h, expected %h (kind %0d key %h)",
                                      best_xor_o, exp_r.best, exp_r.kind, exp_r.key));
          end
          if (status_o !== exp_r.status) begin
            report_mismatch($sformatf("status %0d, expected %0d (kind %0d key %h)",
                                      status_o, exp_r.status, exp_r.kind, exp_r.key));
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Hard stop in case the unit hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, xor_result_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Keeps the pending queue short so the fill loop can react to the
  // predictor's view of the pool.
  task automatic queue_request(input logic kind, input logic [31:0] key);
    request_t req;
    while (request_q.size() >= 4) begin
      @(negedge clk_i);
    end
    req.kind = kind;
    req.key  = key;
    request_q.push_back(req);
  endtask

  // Waits until every request has been taken and every result has come.
  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid_i || xor_result_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Keys from a few shared prefixes keep node use per insert low, so the
  // pool lasts long enough for plenty of deep queries before it fills.
  function automatic logic [31:0] family_key();
    return {prefixes[$urandom_range(PrefixCount - 1)], 10'($urandom())};
  endfunction

  function automatic logic [31:0] stored_pick();
    if (sent_keys.size() == 0) begin
      return $urandom();
    end
    return sent_keys[$urandom_range(sent_keys.size() - 1)];
  endfunction

  task automatic random_request(input int unsigned insert_pct);
    logic        kind;
    logic [31:0] key;
    int unsigned pick;
    kind = ($urandom_range(99) < insert_pct) ? KindInsert : KindQuery;
    pick = $urandom_range(99);
    if (kind == KindInsert) begin
      if (pick < 70) begin
        key = family_key();
      end else if (pick < 85) begin
        key = stored_pick();  // duplicate insert
      end else begin
        key = $urandom();
      end
      sent_keys.push_back(key);
    end else begin
      if (pick < 40) begin
        key = $urandom();
      end else if (pick < 70) begin
        key = family_key();
      end else if (pick < 85) begin
        key = stored_pick();
      end else begin
        key = ~stored_pick();  // best case: whole complement stored
      end
    end
    queue_request(kind, key);
  endtask

  initial begin
    int n;
    next_free    = 1;
    key_total    = 0;
    full_rejects = 0;
    trie_mem[0]  = '0;
    prefixes[0]  = '0;
    prefixes[1]  = '1;
    for (n = 2; n < PrefixCount; n++) begin
      prefixes[n] = 22'($urandom());
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // first pass: slow sender, heavy output stalls
    send_gap_pct   = 23;
    recv_stall_pct = 60;

    // empty set, extremes, duplicates, alternating patterns
    queue_request(KindQuery,  32'h0000_0000);
    queue_request(KindQuery,  32'hFFFF_FFFF);
    queue_request(KindInsert, 32'h0000_0000);
    queue_request(KindQuery,  32'h0000_0000);
    queue_request(KindQuery,  32'hFFFF_FFFF);
    queue_request(KindInsert, 32'hFFFF_FFFF);
    queue_request(KindQuery,  32'h0000_0000);
    queue_request(KindQuery,  32'h8000_0000);
    queue_request(KindInsert, 32'h0000_0000);
    queue_request(KindInsert, 32'hFFFF_FFFF);
    queue_request(KindInsert, 32'h5555_5555);
    queue_request(KindQuery,  32'hAAAA_AAAA);
    queue_request(KindQuery,  32'h5555_5555);
    queue_request(KindInsert, 32'h0000_0001);
    queue_request(KindQuery,  32'h0000_0001);
    queue_request(KindInsert, 32'h8000_0000);
    queue_request(KindQuery,  32'h7FFF_FFFF);
    queue_request(KindQuery,  32'h1234_5678);
    sent_keys.push_back(32'h0000_0000);
    sent_keys.push_back(32'hFFFF_FFFF);
    sent_keys.push_back(32'h5555_5555);

    for (n = 0; n < 380; n++) begin
      random_request(50);
    end

    // sender holds off until the unit has drained completely
    wait_idle();
    send_gap_pct   = 60;
    recv_stall_pct = 23;
    for (n = 0; n < 380; n++) begin
      random_request(45);
    end

    wait_idle();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    for (n = 0; n < 300; n++) begin
      random_request(40);
    end

    // push the pool past its limit, then confirm rejected inserts change
    // nothing, duplicates included
    n = 0;
    while (full_rejects < 12 && n < 800) begin
      random_request(75);
      n++;
    end
    for (n = 0; n < 40; n++) begin
      random_request(50);
    end

    wait_idle();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
